// File: rtl/fsmt_pkg.sv
package fsmt_pkg;

  localparam int unsigned PAGES      = 1024;
  localparam int unsigned PAGE_BYTES = 4096;

  localparam int unsigned NODES      = 2 * PAGES - 1;
  localparam int unsigned FIRST_LEAF = PAGES - 1;

  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned PAGE_W  = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned BYTES_W = 13;
  localparam int unsigned EST_W   = 12;
  localparam int unsigned CAT_W   = 3;
  localparam int unsigned OP_W    = 2;

  localparam int unsigned TH_EMPTY  = PAGE_BYTES * 9 / 10;
  localparam int unsigned TH_AEMPTY = PAGE_BYTES * 2 / 3;
  localparam int unsigned TH_HALF   = PAGE_BYTES / 3;
  localparam int unsigned TH_AFULL  = PAGE_BYTES / 10;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [BYTES_W-1:0] bytes_t;
  typedef logic [EST_W-1:0]   est_t;
  typedef logic [CAT_W-1:0]   cat_t;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_FIND   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam cat_t CAT_NONE   = 3'd0;
  localparam cat_t CAT_AFULL  = 3'd1;
  localparam cat_t CAT_HALF   = 3'd2;
  localparam cat_t CAT_AEMPTY = 3'd3;
  localparam cat_t CAT_EMPTY  = 3'd4;

  // tree memory access for one cycle: one write, two reads
  typedef struct packed {
    logic  we;
    node_t waddr;
    cat_t  wdata;
    node_t raddr0;
    node_t raddr1;
  } mem_req_t;

  function automatic cat_t bytes_to_cat(input bytes_t b);
    cat_t c;
    if (b == '0) begin
      c = CAT_NONE;
    end else if (b >= BYTES_W'(TH_EMPTY)) begin
      c = CAT_EMPTY;
    end else if (b >= BYTES_W'(TH_AEMPTY)) begin
      c = CAT_AEMPTY;
    end else if (b >= BYTES_W'(TH_HALF)) begin
      c = CAT_HALF;
    end else begin
      c = CAT_AFULL;
    end
    return c;
  endfunction

  function automatic est_t cat_to_bytes(input cat_t c);
    est_t e;
    case (c)
      CAT_EMPTY:  e = EST_W'(TH_EMPTY);
      CAT_AEMPTY: e = EST_W'(TH_AEMPTY);
      CAT_HALF:   e = EST_W'(TH_HALF);
      CAT_AFULL:  e = EST_W'(TH_AFULL);
      default:    e = '0;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/fsmt_if.sv
interface fsmt_in_if;
  logic                          valid;
  logic                          ready;
  logic [fsmt_pkg::OP_W-1:0]     op;
  logic [fsmt_pkg::PAGE_W-1:0]   page_index;
  logic [fsmt_pkg::BYTES_W-1:0]  free_bytes;
  logic [fsmt_pkg::BYTES_W-1:0]  needed_bytes;

  modport source(output valid, op, page_index, free_bytes, needed_bytes, input ready);
  modport sink(input valid, op, page_index, free_bytes, needed_bytes, output ready);
endinterface

interface fsmt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [fsmt_pkg::PAGE_W-1:0] found_page;
  logic [fsmt_pkg::EST_W-1:0]  space_estimate;

  modport source(output valid, found, found_page, space_estimate, input ready);
  modport sink(input valid, found, found_page, space_estimate, output ready);
endinterface

// File: rtl/free_space_max_tree.sv
// Free space map over PAGES data pages kept as a binary max-tree of 3-bit space
// categories in one on-chip memory (one write, two registered reads). After reset
// the memory is cleared one node per cycle, which holds in_ch.ready low until every
// node has been cleared; cfg writes are taken throughout. One
// transaction is in flight at a time and every transaction returns exactly one
// result. A query reads its leaf and then offers the category's estimate. An
// update reads its leaf, writes it if the category changes and then carries the
// maximum up one ancestor per step, stopping at the first parent that keeps its
// value or at the root; an unchanged category goes straight to the result. A find
// walks down from the root one level per step. A query or update on a page out of
// range, and a find with no live pages, go straight to the result. Each step waits
// on the read-to-compare loop through the memory: each level needs the previous
// level's read data. A new transaction may be accepted while the last result is
// still waiting in the output register; the next result then waits until that one is taken.
module free_space_max_tree (
  input  logic                         clk,
  input  logic                         rst_n,
  fsmt_in_if.sink                      in_ch,
  fsmt_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [fsmt_pkg::COUNT_W-1:0] cfg_wdata
);

  fsmt_pkg::mem_req_t req;
  fsmt_pkg::cat_t     rdata0;
  fsmt_pkg::cat_t     rdata1;

  fsmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rdata0    (rdata0),
    .rdata1    (rdata1)
  );

  fsmt_tree_mem u_mem (
    .clk    (clk),
    .req    (req),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

endmodule

// File: rtl/fsmt_tree_mem.sv
module fsmt_tree_mem (
  input  logic               clk,
  input  fsmt_pkg::mem_req_t req,
  output fsmt_pkg::cat_t     rdata0,
  output fsmt_pkg::cat_t     rdata1
);

  fsmt_pkg::cat_t mem [fsmt_pkg::NODES];
  fsmt_pkg::cat_t rdata0_r;
  fsmt_pkg::cat_t rdata1_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata0_r <= mem[req.raddr0];
    rdata1_r <= mem[req.raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// File: rtl/fsmt_ctrl.sv
module fsmt_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  fsmt_in_if.sink                   in_ch,
  fsmt_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [fsmt_pkg::COUNT_W-1:0] cfg_wdata,
  output fsmt_pkg::mem_req_t        req,
  input  fsmt_pkg::cat_t            rdata0,
  input  fsmt_pkg::cat_t            rdata1
);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_UCHK = 7'b0000100,
    S_UEV  = 7'b0001000,
    S_FIND = 7'b0010000,
    S_QRY  = 7'b0100000,
    S_PUT  = 7'b1000000
  } state_t;

  localparam fsmt_pkg::node_t LAST_NODE = fsmt_pkg::NODE_W'(fsmt_pkg::NODES - 1);
  localparam fsmt_pkg::node_t LEAF0     = fsmt_pkg::NODE_W'(fsmt_pkg::FIRST_LEAF);
  localparam fsmt_pkg::count_t PAGES_C  = fsmt_pkg::COUNT_W'(fsmt_pkg::PAGES);

  state_t           state_r, state_nxt;
  fsmt_pkg::node_t  node_r, node_nxt;
  fsmt_pkg::cat_t   val_r, val_nxt;
  fsmt_pkg::cat_t   cat_r, cat_nxt;
  fsmt_pkg::count_t pages_r;
  fsmt_pkg::count_t live_n;

  logic             res_found_r, res_found_nxt;
  fsmt_pkg::page_t  res_page_r, res_page_nxt;
  fsmt_pkg::est_t   res_est_r, res_est_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r;
  fsmt_pkg::page_t  out_page_r;
  fsmt_pkg::est_t   out_est_r;
  logic             load_out;

  fsmt_pkg::node_t  in_leaf;
  logic             in_range;
  fsmt_pkg::node_t  par;
  fsmt_pkg::cat_t   mx;
  fsmt_pkg::node_t  lchild, rchild, next_node;
  logic             go_left, go_right;
  fsmt_pkg::page_t  land_page;

  function automatic fsmt_pkg::node_t sib_of(input fsmt_pkg::node_t n);
    return n[0] ? n + 1'b1 : n - 1'b1;
  endfunction

  function automatic fsmt_pkg::node_t par_of(input fsmt_pkg::node_t n);
    fsmt_pkg::node_t m;
    m = n - 1'b1;
    return m >> 1;
  endfunction

  assign live_n   = (pages_r > PAGES_C) ? PAGES_C : pages_r;
  assign in_leaf  = LEAF0 + fsmt_pkg::NODE_W'(in_ch.page_index);
  assign in_range = {1'b0, in_ch.page_index} < live_n;

  assign par = par_of(node_r);
  assign mx  = (val_r > rdata0) ? val_r : rdata0;

  assign lchild    = {node_r[fsmt_pkg::NODE_W-2:0], 1'b1};
  assign rchild    = lchild + 1'b1;
  assign go_left   = rdata0 >= cat_r;
  assign go_right  = rdata1 >= cat_r;
  assign next_node = go_left ? lchild : rchild;
  assign land_page = fsmt_pkg::PAGE_W'(next_node - LEAF0);

  assign in_ch.ready = (state_r == S_IDLE);
  assign load_out    = (state_r == S_PUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    val_nxt       = val_r;
    cat_nxt       = cat_r;
    res_found_nxt = res_found_r;
    res_page_nxt  = res_page_r;
    res_est_nxt   = res_est_r;
    req           = '0;

    case (state_r)
      S_CLR: begin
        req.we    = 1'b1;
        req.waddr = node_r;
        req.wdata = fsmt_pkg::CAT_NONE;
        node_nxt  = node_r + 1'b1;
        if (node_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        req.raddr0 = in_leaf;
        if (in_ch.valid) begin
          res_found_nxt = 1'b0;
          res_page_nxt  = '0;
          res_est_nxt   = '0;
          state_nxt     = S_PUT;
          case (in_ch.op)
            fsmt_pkg::OP_UPDATE: begin
              if (in_range) begin
                node_nxt  = in_leaf;
                cat_nxt   = fsmt_pkg::bytes_to_cat(in_ch.free_bytes);
                state_nxt = S_UCHK;
              end
            end
            fsmt_pkg::OP_FIND: begin
              req.raddr0 = fsmt_pkg::NODE_W'(1);
              req.raddr1 = fsmt_pkg::NODE_W'(2);
              if (live_n != '0) begin
                node_nxt  = '0;
                cat_nxt   = fsmt_pkg::bytes_to_cat(in_ch.needed_bytes);
                state_nxt = S_FIND;
              end
            end
            fsmt_pkg::OP_QUERY: begin
              if (in_range) begin
                state_nxt = S_QRY;
              end
            end
            default: begin
              state_nxt = S_PUT;
            end
          endcase
        end
      end
      S_UCHK: begin
        if (rdata0 == cat_r) begin
          state_nxt = S_PUT;
        end else begin
          req.we     = 1'b1;
          req.waddr  = node_r;
          req.wdata  = cat_r;
          req.raddr0 = sib_of(node_r);
          req.raddr1 = par;
          val_nxt    = cat_r;
          state_nxt  = S_UEV;
        end
      end
      S_UEV: begin
        // rdata0 = sibling, rdata1 = parent; stop once the parent keeps its value or the root is written
        if (mx == rdata1) begin
          state_nxt = S_PUT;
        end else begin
          req.we     = 1'b1;
          req.waddr  = par;
          req.wdata  = mx;
          req.raddr0 = sib_of(par);
          req.raddr1 = par_of(par);
          val_nxt    = mx;
          node_nxt   = par;
          if (par == '0) begin
            state_nxt = S_PUT;
          end
        end
      end
      S_FIND: begin
        req.raddr0 = {next_node[fsmt_pkg::NODE_W-2:0], 1'b1};
        req.raddr1 = {next_node[fsmt_pkg::NODE_W-2:0], 1'b1} + 1'b1;
        node_nxt   = next_node;
        if (!go_left && !go_right) begin
          state_nxt = S_PUT;
        end else if (next_node >= LEAF0) begin
          // landing on a stale page beyond the count reports not found
          if ({1'b0, land_page} < live_n) begin
            res_found_nxt = 1'b1;
            res_page_nxt  = land_page;
          end
          state_nxt = S_PUT;
        end
      end
      S_QRY: begin
        res_est_nxt = fsmt_pkg::cat_to_bytes(rdata0);
        state_nxt   = S_PUT;
      end
      S_PUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      node_r      <= '0;
      pages_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      node_r      <= node_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        pages_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    cat_r       <= cat_nxt;
    res_found_r <= res_found_nxt;
    res_page_r  <= res_page_nxt;
    res_est_r   <= res_est_nxt;
    if (load_out) begin
      out_found_r <= res_found_r;
      out_page_r  <= res_page_r;
      out_est_r   <= res_est_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.found_page     = out_page_r;
  assign out_ch.space_estimate = out_est_r;

endmodule

// File: rtl/fsmt_checker.sv
module fsmt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        found,
  input logic [fsmt_pkg::PAGE_W-1:0] found_page,
  input logic [fsmt_pkg::EST_W-1:0]  space_estimate
);

  // clearing pass keeps input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // one transaction at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(found_page)
      && $stable(space_estimate))
    else $error("stalled result changed");

  a_page_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> found_page == '0)
    else $error("page reported without a hit");

  a_find_no_estimate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> space_estimate == '0)
    else $error("find result carries an estimate");

endmodule

bind free_space_max_tree fsmt_checker u_fsmt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .found          (out_ch.found),
  .found_page     (out_ch.found_page),
  .space_estimate (out_ch.space_estimate)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 20000;  // covers the clearing pass and the long hold-off
  localparam int LONG_HOLD   = 200;
  localparam int DRAIN_SLACK = 16;
  localparam int MAX_PRINTS  = 50;

  typedef struct packed {
    logic            found;
    fsmt_pkg::page_t found_page;
    fsmt_pkg::est_t  space_estimate;
  } space_answer_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  fsmt_pkg::count_t cfg_wdata;

  fsmt_in_if  in_ch ();
  fsmt_out_if out_ch ();

  free_space_max_tree i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fsmt_pkg::cat_t   cat_tree_model [fsmt_pkg::NODES];
  fsmt_pkg::count_t page_count_model;
  space_answer_t    answer_q [$];
  int               err_cnt;
  bit               sender_gaps;
  bit               sink_gaps;
  bit               hold_off_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic fsmt_pkg::cat_t class_of_bytes(fsmt_pkg::bytes_t b);
    if (b == '0) return fsmt_pkg::CAT_NONE;
    if (b >= fsmt_pkg::BYTES_W'(fsmt_pkg::TH_EMPTY)) return fsmt_pkg::CAT_EMPTY;
    if (b >= fsmt_pkg::BYTES_W'(fsmt_pkg::TH_AEMPTY)) return fsmt_pkg::CAT_AEMPTY;
    if (b >= fsmt_pkg::BYTES_W'(fsmt_pkg::TH_HALF)) return fsmt_pkg::CAT_HALF;
    return fsmt_pkg::CAT_AFULL;
  endfunction

  function automatic fsmt_pkg::est_t bytes_of_class(fsmt_pkg::cat_t c);
    case (c)
      fsmt_pkg::CAT_EMPTY:  return fsmt_pkg::EST_W'(fsmt_pkg::TH_EMPTY);
      fsmt_pkg::CAT_AEMPTY: return fsmt_pkg::EST_W'(fsmt_pkg::TH_AEMPTY);
      fsmt_pkg::CAT_HALF:   return fsmt_pkg::EST_W'(fsmt_pkg::TH_HALF);
      fsmt_pkg::CAT_AFULL:  return fsmt_pkg::EST_W'(fsmt_pkg::TH_AFULL);
      default:              return '0;
    endcase
  endfunction

  // counts above PAGES behave as PAGES
  function automatic int unsigned live_page_count();
    int unsigned n;
    n = page_count_model;
    if (n > fsmt_pkg::PAGES) n = fsmt_pkg::PAGES;
    return n;
  endfunction

  function automatic space_answer_t predict_answer(fsmt_pkg::op_t op, fsmt_pkg::page_t pg,
                                                   fsmt_pkg::bytes_t fb, fsmt_pkg::bytes_t nb);
    space_answer_t  ans;
    int unsigned    n, node, par, cur;
    fsmt_pkg::cat_t c, need, lv, rv, m;
    bit             hit, settled;
    ans = '0;
    n   = live_page_count();
    case (op)
      fsmt_pkg::OP_UPDATE: begin
        if (n != 0 && pg < n) begin
          node = fsmt_pkg::FIRST_LEAF + pg;
          c    = class_of_bytes(fb);
          if (cat_tree_model[node] != c) begin
            cat_tree_model[node] = c;
            settled = 1'b0;
            // carry maxima up, stop at the first parent that keeps its value
            while (node > 0 && !settled) begin
              par = (node - 1) / 2;
              lv  = cat_tree_model[2 * par + 1];
              rv  = cat_tree_model[2 * par + 2];
              m   = (lv > rv) ? lv : rv;
              if (m == cat_tree_model[par]) begin
                settled = 1'b1;
              end else begin
                cat_tree_model[par] = m;
                node = par;
              end
            end
          end
        end
      end
      fsmt_pkg::OP_FIND: begin
        if (n != 0) begin
          need = class_of_bytes(nb);
          cur  = 0;
          hit  = 1'b1;
          while (hit && cur < fsmt_pkg::FIRST_LEAF) begin
            if (cat_tree_model[2 * cur + 1] >= need) begin
              cur = 2 * cur + 1;
            end else if (cat_tree_model[2 * cur + 2] >= need) begin
              cur = 2 * cur + 2;
            end else begin
              hit = 1'b0;
            end
          end
          // no backing up when the leftmost leaf lies past the live count
          if (hit && (cur - fsmt_pkg::FIRST_LEAF) < n) begin
            ans.found      = 1'b1;
            ans.found_page = fsmt_pkg::page_t'(cur - fsmt_pkg::FIRST_LEAF);
          end
        end
      end
      fsmt_pkg::OP_QUERY: begin
        if (n != 0 && pg < n) begin
          ans.space_estimate = bytes_of_class(cat_tree_model[fsmt_pkg::FIRST_LEAF + pg]);
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  // ---------------- drivers ----------------

  task automatic send_item(fsmt_pkg::op_t op, fsmt_pkg::page_t pg, fsmt_pkg::bytes_t fb,
                           fsmt_pkg::bytes_t nb);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.page_index   <= pg;
    in_ch.free_bytes   <= fb;
    in_ch.needed_bytes <= nb;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    answer_q.insert(answer_q.size(), predict_answer(op, pg, fb, nb));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic set_page_count(fsmt_pkg::count_t v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    page_count_model = v;
    @(posedge clk);
  endtask

  // bytes biased toward the category thresholds
  function automatic fsmt_pkg::bytes_t pick_bytes();
    int unsigned th;
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: begin
        case ($urandom_range(0, 3))
          0:       th = fsmt_pkg::TH_EMPTY;
          1:       th = fsmt_pkg::TH_AEMPTY;
          2:       th = fsmt_pkg::TH_HALF;
          default: th = 1;
        endcase
        return fsmt_pkg::bytes_t'(th + $urandom_range(0, 2) - 1);
      end
      3:       return fsmt_pkg::bytes_t'($urandom_range(0, 8191));
      default: return fsmt_pkg::bytes_t'($urandom_range(0, fsmt_pkg::PAGE_BYTES));
    endcase
  endfunction

  task automatic send_random_item();
    int unsigned     n, pick;
    fsmt_pkg::op_t   op;
    fsmt_pkg::page_t pg;
    n    = live_page_count();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      op = fsmt_pkg::OP_NONE;
    end else if (pick < 50) begin
      op = fsmt_pkg::OP_UPDATE;
    end else if (pick < 75) begin
      op = fsmt_pkg::OP_FIND;
    end else begin
      op = fsmt_pkg::OP_QUERY;
    end
    if (n == 0 || $urandom_range(0, 9) == 0) begin
      pg = fsmt_pkg::page_t'($urandom_range(0, 1023));
    end else begin
      pg = fsmt_pkg::page_t'($urandom_range(0, n - 1));
    end
    send_item(op, pg, pick_bytes(), pick_bytes());
  endtask

  // ---------------- result side ----------------

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_answer();
    space_answer_t want;
    if (answer_q.size() == 0) begin
      report_mismatch($sformatf("result with no transaction pending: found=%0d page=%0d est=%0d",
                                out_ch.found, out_ch.found_page, out_ch.space_estimate));
    end else begin
      want = answer_q.pop_front();
      if (out_ch.found !== want.found)
        report_mismatch($sformatf("found %0d, want %0d", out_ch.found, want.found));
      if (out_ch.found_page !== want.found_page)
        report_mismatch($sformatf("found_page %0d, want %0d", out_ch.found_page,
                                  want.found_page));
      if (out_ch.space_estimate !== want.space_estimate)
        report_mismatch($sformatf("space_estimate %0d, want %0d", out_ch.space_estimate,
                                  want.space_estimate));
    end
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_answer();
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LONG_HOLD;
      end else if (stall_left == 0 && sink_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------- tests ----------------

  // page count still zero after reset: everything answers zero
  task automatic test_uninitialized();
    send_item(fsmt_pkg::OP_UPDATE, 10'd0, fsmt_pkg::bytes_t'(fsmt_pkg::PAGE_BYTES), '0);
    send_item(fsmt_pkg::OP_FIND, 10'd0, '0, '0);
    send_item(fsmt_pkg::OP_QUERY, 10'd0, '0, '0);
    send_item(fsmt_pkg::OP_NONE, 10'd1023, 13'h1fff, 13'h1fff);
  endtask

  task automatic test_directed();
    wait_drained();
    set_page_count(11'd1024);
    send_item(fsmt_pkg::OP_FIND, 10'd0, '0, '0);                // zero need -> page 0
    send_item(fsmt_pkg::OP_FIND, 10'd0, '0, 13'd1);             // empty tree, miss
    send_item(fsmt_pkg::OP_UPDATE, 10'd1023, 13'h1fff, '0);
    send_item(fsmt_pkg::OP_FIND, 10'd0, '0, 13'h1fff);          // need above page size
    send_item(fsmt_pkg::OP_UPDATE, 10'd700, fsmt_pkg::bytes_t'(fsmt_pkg::TH_EMPTY), '0);
    send_item(fsmt_pkg::OP_FIND, 10'd0, '0, fsmt_pkg::bytes_t'(fsmt_pkg::PAGE_BYTES));
    send_item(fsmt_pkg::OP_UPDATE, 10'd700, 13'd4000, '0);      // same category, no write
    send_item(fsmt_pkg::OP_UPDATE, 10'd0, fsmt_pkg::bytes_t'(fsmt_pkg::TH_AEMPTY - 1), '0);
    send_item(fsmt_pkg::OP_UPDATE, 10'd1, fsmt_pkg::bytes_t'(fsmt_pkg::TH_AEMPTY), '0);
    send_item(fsmt_pkg::OP_UPDATE, 10'd2, fsmt_pkg::bytes_t'(fsmt_pkg::TH_HALF - 1), '0);
    send_item(fsmt_pkg::OP_UPDATE, 10'd3, fsmt_pkg::bytes_t'(fsmt_pkg::TH_HALF), '0);
    send_item(fsmt_pkg::OP_UPDATE, 10'd4, 13'd1, '0);
    send_item(fsmt_pkg::OP_FIND, 10'd0, '0, fsmt_pkg::bytes_t'(fsmt_pkg::TH_AEMPTY));
    send_item(fsmt_pkg::OP_QUERY, 10'd0, '0, '0);
    send_item(fsmt_pkg::OP_QUERY, 10'd1, '0, '0);
    send_item(fsmt_pkg::OP_QUERY, 10'd2, '0, '0);
    send_item(fsmt_pkg::OP_QUERY, 10'd4, '0, '0);
    send_item(fsmt_pkg::OP_QUERY, 10'd1023, '0, '0);
    wait_drained();
    set_page_count(11'd5);
    // lands on page 700, past count
    send_item(fsmt_pkg::OP_FIND, 10'd0, '0, fsmt_pkg::bytes_t'(fsmt_pkg::PAGE_BYTES));
    send_item(fsmt_pkg::OP_QUERY, 10'd700, '0, '0);
    send_item(fsmt_pkg::OP_UPDATE, 10'd900, fsmt_pkg::bytes_t'(fsmt_pkg::PAGE_BYTES), '0);
    send_item(fsmt_pkg::OP_NONE, 10'd1023, 13'h1fff, 13'h1fff);
    wait_drained();
    set_page_count(11'd2047);                                   // acts as full size, tree kept
    send_item(fsmt_pkg::OP_QUERY, 10'd1023, '0, '0);
    send_item(fsmt_pkg::OP_FIND, 10'd0, '0, 13'd1);
    send_item(fsmt_pkg::OP_UPDATE, 10'd1023, '0, '0);
    send_item(fsmt_pkg::OP_QUERY, 10'd1023, '0, '0);
  endtask

  task automatic test_random_phases();
    fsmt_pkg::count_t counts [8];
    counts = '{11'd1, 11'd2, 11'd3, 11'd16, 11'd1024, 11'd600, 11'd2047, 11'd0};
    foreach (counts[i]) begin
      wait_drained();
      if (i == 7) begin
        set_page_count(fsmt_pkg::count_t'($urandom_range(0, 2047)));
      end else begin
        set_page_count(counts[i]);
      end
      repeat (105) send_random_item();
    end
  endtask

  // sink holds off while the source keeps offering, then the source waits for all results
  task automatic test_backpressure();
    wait_drained();
    set_page_count(11'd1024);
    sender_gaps  = 1'b0;
    hold_off_req = 1'b1;
    repeat (24) send_random_item();
    wait_drained();
    sender_gaps = 1'b1;
  endtask

  task automatic test_steady_stream();
    wait_drained();
    set_page_count(11'd1000);
    sender_gaps = 1'b0;
    sink_gaps   = 1'b0;
    repeat (80) send_random_item();
  endtask

  initial begin : test_sequence
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= fsmt_pkg::OP_UPDATE;
    in_ch.page_index   <= '0;
    in_ch.free_bytes   <= '0;
    in_ch.needed_bytes <= '0;
    err_cnt          = 0;
    sender_gaps      = 1'b1;
    sink_gaps        = 1'b1;
    hold_off_req     = 1'b0;
    page_count_model = '0;
    foreach (cat_tree_model[i]) cat_tree_model[i] = fsmt_pkg::CAT_NONE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_uninitialized();
    test_directed();
    test_random_phases();
    test_backpressure();
    test_steady_stream();
    wait_drained();

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
